@@ hw/rtl/bbf_pkg.sv @@
// shared widths and types for the bilinear block fill pixel core
package bbf_pkg;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned PROD_W  = COORD_W + GRAY_W;
  localparam int unsigned NUM_W   = 2 * COORD_W + GRAY_W;
  localparam int unsigned DEN_W   = 2 * COORD_W;
  localparam int unsigned TERMS   = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [GRAY_W-1:0]  gray_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [DEN_W-1:0]   den_t;

  // block shape decides which corner terms take part
  typedef enum logic [1:0] {
    SHAPE_FULL,
    SHAPE_COL,
    SHAPE_ROW,
    SHAPE_POINT
  } shape_t;

  // pixel position and inside flag, carried alongside the arithmetic
  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   in_block;
  } meta_t;

endpackage

@@ hw/rtl/bbf_in_if.sv @@
// input channel: block corners, corner grays and pixel position
interface bbf_in_if import bbf_pkg::*; ();

  logic   valid;
  logic   ready;
  coord_t col_first;
  coord_t row_first;
  coord_t col_last;
  coord_t row_last;
  gray_t  gray_top_left;
  gray_t  gray_top_right;
  gray_t  gray_bottom_left;
  gray_t  gray_bottom_right;
  coord_t pixel_col;
  coord_t pixel_row;

  modport source (
    output valid, col_first, row_first, col_last, row_last,
    output gray_top_left, gray_top_right, gray_bottom_left, gray_bottom_right,
    output pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, col_first, row_first, col_last, row_last,
    input  gray_top_left, gray_top_right, gray_bottom_left, gray_bottom_right,
    input  pixel_col, pixel_row,
    output ready
  );

endinterface

@@ hw/rtl/bbf_out_if.sv @@
// result channel: interpolated gray level and pixel position
interface bbf_out_if import bbf_pkg::*; ();

  logic   valid;
  logic   ready;
  gray_t  pixel_value;
  coord_t out_col;
  coord_t out_row;
  logic   inside_res;

  modport source (
    output valid, pixel_value, out_col, out_row, inside_res,
    input  ready
  );

  modport sink (
    input  valid, pixel_value, out_col, out_row, inside_res,
    output ready
  );

endinterface

@@ hw/rtl/bbf_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module bbf_div
  import bbf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  logic  in_valid,
  input  num_t  in_num,
  input  den_t  in_den,
  input  meta_t in_meta,
  output logic  out_valid,
  output gray_t out_quo,
  output meta_t out_meta
);

  logic  valid_r [GRAY_W];
  gray_t quo_r   [GRAY_W];
  meta_t meta_r  [GRAY_W];
  num_t  rem_r   [GRAY_W-1];
  den_t  den_r   [GRAY_W-1];

  for (genvar k = 0; k < GRAY_W; k++) begin : g_stage
    localparam int unsigned SH = GRAY_W - 1 - k;

    logic  valid_in;
    num_t  rem_in;
    den_t  den_in;
    gray_t quo_in;
    meta_t meta_in;
    num_t  dsh;
    logic  take;

    // stage inputs: from the ports or from the previous stage
    if (k == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_num;
      assign den_in   = in_den;
      assign quo_in   = '0;
      assign meta_in  = in_meta;
    end else begin : g_next
      assign valid_in = valid_r[k-1];
      assign rem_in   = rem_r[k-1];
      assign den_in   = den_r[k-1];
      assign quo_in   = quo_r[k-1];
      assign meta_in  = meta_r[k-1];
    end

    // trial subtract of the shifted divisor
    assign dsh  = num_t'(den_in) << SH;
    assign take = (rem_in >= dsh);

    // valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (adv) begin
        valid_r[k] <= valid_in;
      end
    end

    // quotient and position
    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[k]  <= {quo_in[GRAY_W-2:0], take};
        meta_r[k] <= meta_in;
      end
    end

    // partial remainder for the next stage
    if (k < GRAY_W - 1) begin : g_carry
      num_t rem_nxt;

      assign rem_nxt = take ? num_t'(rem_in - dsh) : rem_in;

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = valid_r[GRAY_W-1];
  assign out_quo   = quo_r[GRAY_W-1];
  assign out_meta  = meta_r[GRAY_W-1];

endmodule

@@ hw/rtl/bilinear_block_fill_pixel_core.sv @@
// Bilinear block fill pixel core: takes one word per clock naming a block, its four corner
// grays and a pixel, and returns the pixel's gray level by exact bilinear interpolation,
// truncated, or zero with inside_res low when the pixel is outside or the corners are
// unordered. A word is accepted every cycle and its result passes through six stages of
// compare, factor select, two multiplies and a two-level add, then eight stages of a
// restoring divider that yields one quotient bit each. The last divider stage is the output
// register; while it holds a word that is not taken the whole pipeline holds and in ready is
// low, otherwise in ready stays high.
module bilinear_block_fill_pixel_core
  import bbf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bbf_in_if.sink    in_bus,
  bbf_out_if.source out_bus
);

  localparam coord_t ONE = coord_t'(1);

  logic adv;

  // stage 1: ordering, inside test, spans and offsets
  logic   s1_valid_r;
  meta_t  s1_meta_r, s1_meta_nxt;
  shape_t s1_shape_r, s1_shape_nxt;
  coord_t s1_w_r, s1_h_r, s1_dx_r, s1_dy_r;
  gray_t  s1_gtl_r, s1_gtr_r, s1_gbl_r, s1_gbr_r;

  // stage 2: per-term factors
  logic   s2_valid_r;
  meta_t  s2_meta_r;
  gray_t  s2_g_r [TERMS];
  coord_t s2_a_r [TERMS];
  coord_t s2_b_r [TERMS];
  coord_t s2_da_r, s2_db_r;
  gray_t  s2_g_nxt [TERMS];
  coord_t s2_a_nxt [TERMS];
  coord_t s2_b_nxt [TERMS];
  coord_t s2_da_nxt, s2_db_nxt;

  // stage 3: first products
  logic   s3_valid_r;
  meta_t  s3_meta_r;
  prod_t  s3_p_r [TERMS];
  coord_t s3_b_r [TERMS];
  den_t   s3_den_r;

  // stage 4: full terms
  logic   s4_valid_r;
  meta_t  s4_meta_r;
  num_t   s4_t_r [TERMS];
  den_t   s4_den_r;

  // stage 5: pair sums
  logic   s5_valid_r;
  meta_t  s5_meta_r;
  num_t   s5_lo_r, s5_hi_r;
  den_t   s5_den_r;

  // stage 6: numerator
  logic   s6_valid_r;
  meta_t  s6_meta_r;
  num_t   s6_num_r;
  den_t   s6_den_r;

  logic   dv_valid;
  gray_t  dv_quo;
  meta_t  dv_meta;

  // global advance: move when the output register is empty or being taken
  assign adv          = !dv_valid || out_bus.ready;
  assign in_bus.ready = adv;

  // stage 1 logic
  always_comb begin
    s1_meta_nxt.col      = in_bus.pixel_col;
    s1_meta_nxt.row      = in_bus.pixel_row;
    s1_meta_nxt.in_block = (in_bus.col_first <= in_bus.col_last) &&
                           (in_bus.row_first <= in_bus.row_last) &&
                           (in_bus.pixel_col >= in_bus.col_first) &&
                           (in_bus.pixel_col <= in_bus.col_last) &&
                           (in_bus.pixel_row >= in_bus.row_first) &&
                           (in_bus.pixel_row <= in_bus.row_last);
    if (in_bus.col_first == in_bus.col_last && in_bus.row_first == in_bus.row_last) begin
      s1_shape_nxt = SHAPE_POINT;
    end else if (in_bus.col_first == in_bus.col_last) begin
      s1_shape_nxt = SHAPE_COL;
    end else if (in_bus.row_first == in_bus.row_last) begin
      s1_shape_nxt = SHAPE_ROW;
    end else begin
      s1_shape_nxt = SHAPE_FULL;
    end
  end

  // stage 2 logic: weights of each corner for the block shape
  always_comb begin
    s2_g_nxt[0] = s1_gtl_r;
    s2_g_nxt[1] = s1_gtr_r;
    s2_g_nxt[2] = s1_gbl_r;
    s2_g_nxt[3] = s1_gbr_r;
    s2_a_nxt[0] = coord_t'(s1_w_r - s1_dx_r);
    s2_a_nxt[1] = s1_dx_r;
    s2_a_nxt[2] = coord_t'(s1_w_r - s1_dx_r);
    s2_a_nxt[3] = s1_dx_r;
    s2_b_nxt[0] = coord_t'(s1_h_r - s1_dy_r);
    s2_b_nxt[1] = coord_t'(s1_h_r - s1_dy_r);
    s2_b_nxt[2] = s1_dy_r;
    s2_b_nxt[3] = s1_dy_r;
    s2_da_nxt   = s1_w_r;
    s2_db_nxt   = s1_h_r;
    case (s1_shape_r)
      SHAPE_FULL: begin
      end
      SHAPE_COL: begin
        // top-left to bottom-right along rows
        s2_g_nxt[1] = '0;
        s2_g_nxt[2] = '0;
        for (int i = 0; i < TERMS; i++) begin
          s2_a_nxt[i] = ONE;
        end
        s2_b_nxt[0] = coord_t'(s1_h_r - s1_dy_r);
        s2_b_nxt[3] = s1_dy_r;
        s2_da_nxt   = ONE;
      end
      SHAPE_ROW: begin
        // top-left to bottom-right along columns
        s2_g_nxt[1] = '0;
        s2_g_nxt[2] = '0;
        for (int i = 0; i < TERMS; i++) begin
          s2_b_nxt[i] = ONE;
        end
        s2_a_nxt[0] = coord_t'(s1_w_r - s1_dx_r);
        s2_a_nxt[3] = s1_dx_r;
        s2_db_nxt   = ONE;
      end
      SHAPE_POINT: begin
        // top-left gray over one
        s2_g_nxt[1] = '0;
        s2_g_nxt[2] = '0;
        s2_g_nxt[3] = '0;
        for (int i = 0; i < TERMS; i++) begin
          s2_a_nxt[i] = ONE;
          s2_b_nxt[i] = ONE;
        end
        s2_da_nxt = ONE;
        s2_db_nxt = ONE;
      end
      default: begin
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_bus.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
      s6_valid_r <= s5_valid_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta_r  <= s1_meta_nxt;
      s1_shape_r <= s1_shape_nxt;
      s1_w_r     <= coord_t'(in_bus.col_last - in_bus.col_first);
      s1_h_r     <= coord_t'(in_bus.row_last - in_bus.row_first);
      s1_dx_r    <= coord_t'(in_bus.pixel_col - in_bus.col_first);
      s1_dy_r    <= coord_t'(in_bus.pixel_row - in_bus.row_first);
      s1_gtl_r   <= in_bus.gray_top_left;
      s1_gtr_r   <= in_bus.gray_top_right;
      s1_gbl_r   <= in_bus.gray_bottom_left;
      s1_gbr_r   <= in_bus.gray_bottom_right;

      s2_meta_r <= s1_meta_r;
      s2_da_r   <= s2_da_nxt;
      s2_db_r   <= s2_db_nxt;

      s3_meta_r <= s2_meta_r;
      s3_den_r  <= den_t'(s2_da_r) * den_t'(s2_db_r);

      s4_meta_r <= s3_meta_r;
      s4_den_r  <= s3_den_r;

      for (int i = 0; i < TERMS; i++) begin
        s2_g_r[i] <= s2_g_nxt[i];
        s2_a_r[i] <= s2_a_nxt[i];
        s2_b_r[i] <= s2_b_nxt[i];
        s3_p_r[i] <= prod_t'(s2_g_r[i]) * prod_t'(s2_a_r[i]);
        s3_b_r[i] <= s2_b_r[i];
        s4_t_r[i] <= num_t'(s3_p_r[i]) * num_t'(s3_b_r[i]);
      end

      s5_meta_r <= s4_meta_r;
      s5_lo_r   <= num_t'(s4_t_r[0] + s4_t_r[1]);
      s5_hi_r   <= num_t'(s4_t_r[2] + s4_t_r[3]);
      s5_den_r  <= s4_den_r;

      // a pixel outside the block divides zero
      s6_meta_r <= s5_meta_r;
      s6_num_r  <= s5_meta_r.in_block ? num_t'(s5_lo_r + s5_hi_r) : '0;
      s6_den_r  <= s5_den_r;
    end
  end

  // divide numerator by block area
  bbf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s6_valid_r),
    .in_num    (s6_num_r),
    .in_den    (s6_den_r),
    .in_meta   (s6_meta_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_meta  (dv_meta)
  );

  // result word
  assign out_bus.valid       = dv_valid;
  assign out_bus.pixel_value = dv_quo;
  assign out_bus.out_col     = dv_meta.col;
  assign out_bus.out_row     = dv_meta.row;
  assign out_bus.inside_res  = dv_meta.in_block;

endmodule

@@ hw/rtl/bbf_chk.sv @@
// port checker for the bilinear block fill pixel core, with its bind
module bbf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pixel_value,
  input logic [11:0] out_col,
  input logic [11:0] out_row,
  input logic        inside_res
);

  // a waiting result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a waiting result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pixel_value) && $stable(out_col) &&
                               $stable(out_row) && $stable(inside_res))
    else $error("result word changed while stalled");

  // outside pixels read as zero
  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !inside_res |-> pixel_value == 8'd0)
    else $error("nonzero value for pixel outside block");

  // empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stalled output holds the whole pipeline, input included
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind bilinear_block_fill_pixel_core bbf_chk u_bbf_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .pixel_value (out_bus.pixel_value),
  .out_col     (out_bus.out_col),
  .out_row     (out_bus.out_row),
  .inside_res  (out_bus.inside_res)
);

@@ dv/bbf_pixel_checker.sv @@
// scoreboard for the bilinear block fill pixel core: predicts each pixel and checks each result
module bbf_pixel_checker
  import bbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bbf_in_if           in_mon,
  bbf_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct packed {
    gray_t  value;
    coord_t col;
    coord_t row;
    logic   in_block;
  } pixel_result_t;

  // predicted pixels, oldest first
  pixel_result_t pixel_q[$];

  // exact bilinear value of one pixel, truncated
  function automatic pixel_result_t interp_pixel(
    coord_t cf, coord_t rf, coord_t cl, coord_t rl,
    gray_t gtl, gray_t gtr, gray_t gbl, gray_t gbr,
    coord_t pc, coord_t pr
  );
    pixel_result_t   res;
    longint unsigned w, h, dx, dy, a, b, c, d, q;
    shape_t          shape;
    res.col      = pc;
    res.row      = pr;
    res.value    = '0;
    res.in_block = (cf <= cl) && (rf <= rl) && (pc >= cf) && (pc <= cl) &&
                   (pr >= rf) && (pr <= rl);
    if (res.in_block) begin
      w  = longint'(cl) - longint'(cf);
      h  = longint'(rl) - longint'(rf);
      dx = longint'(pc) - longint'(cf);
      dy = longint'(pr) - longint'(rf);
      a  = longint'(gtl);
      b  = longint'(gtr);
      c  = longint'(gbl);
      d  = longint'(gbr);
      if (w == 0 && h == 0) shape = SHAPE_POINT;
      else if (w == 0)      shape = SHAPE_COL;
      else if (h == 0)      shape = SHAPE_ROW;
      else                  shape = SHAPE_FULL;
      // degenerate blocks run straight from top left to bottom right
      case (shape)
        SHAPE_POINT: q = a;
        SHAPE_COL:   q = (a * (h - dy) + d * dy) / h;
        SHAPE_ROW:   q = (a * (w - dx) + d * dx) / w;
        default:     q = (a * (w - dx) * (h - dy) + b * dx * (h - dy) +
                          c * (w - dx) * dy + d * dx * dy) / (w * h);
      endcase
      res.value = gray_t'(q);
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin : monitor
    pixel_result_t exp_r;
    if (!rst_n) begin
      pixel_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pixel_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word, expected none actual col %0d row %0d", $time,
                   out_mon.out_col, out_mon.out_row);
        end else begin
          exp_r = pixel_q.pop_front();
          check_field("pixel_value", 16'(exp_r.value), 16'(out_mon.pixel_value));
          check_field("out_col", 16'(exp_r.col), 16'(out_mon.out_col));
          check_field("out_row", 16'(exp_r.row), 16'(out_mon.out_row));
          check_field("inside_res", 16'(exp_r.in_block), 16'(out_mon.inside_res));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pixel_q.push_back(interp_pixel(in_mon.col_first, in_mon.row_first,
                                       in_mon.col_last, in_mon.row_last,
                                       in_mon.gray_top_left, in_mon.gray_top_right,
                                       in_mon.gray_bottom_left, in_mon.gray_bottom_right,
                                       in_mon.pixel_col, in_mon.pixel_row));
      end
    end
    pending_count = pixel_q.size();
  end

endmodule

@@ dv/bilinear_block_fill_pixel_core_tb.sv @@
// testbench top for the bilinear block fill pixel core: stimulus, back pressure and verdict
module bilinear_block_fill_pixel_core_tb;
  import bbf_pkg::*;

  localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;

  typedef struct {
    coord_t cf, rf, cl, rl;
    gray_t  gtl, gtr, gbl, gbr;
    coord_t pc, pr;
  } fill_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          idle_on;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned stall_left;

  bbf_in_if  in_bus();
  bbf_out_if out_bus();

  bilinear_block_fill_pixel_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  bbf_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic fill_word_t mk_word(
    int unsigned cf, int unsigned rf, int unsigned cl, int unsigned rl,
    int unsigned gtl, int unsigned gtr, int unsigned gbl, int unsigned gbr,
    int unsigned pc, int unsigned pr
  );
    fill_word_t w;
    w.cf  = coord_t'(cf);
    w.rf  = coord_t'(rf);
    w.cl  = coord_t'(cl);
    w.rl  = coord_t'(rl);
    w.gtl = gray_t'(gtl);
    w.gtr = gray_t'(gtr);
    w.gbl = gray_t'(gbl);
    w.gbr = gray_t'(gbr);
    w.pc  = coord_t'(pc);
    w.pr  = coord_t'(pr);
    return w;
  endfunction

  // block extent: mostly small, some flat, a few up to the whole coordinate range
  function automatic int unsigned rand_span();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3)  return 0;
    if (r < 16) return $urandom_range(1, 15);
    if (r < 19) return $urandom_range(16, 255);
    return $urandom_range(256, COORD_MAX);
  endfunction

  // mostly ordered blocks with the pixel inside, the rest stray pixels and raw noise
  function automatic fill_word_t rand_word();
    fill_word_t  w;
    int unsigned pick, span_c, span_r;
    pick  = $urandom_range(0, 99);
    w.gtl = gray_t'($urandom);
    w.gtr = gray_t'($urandom);
    w.gbl = gray_t'($urandom);
    w.gbr = gray_t'($urandom);
    w.pc  = coord_t'($urandom);
    w.pr  = coord_t'($urandom);
    if (pick < 85) begin
      span_c = rand_span();
      span_r = rand_span();
      w.cf = coord_t'($urandom_range(0, COORD_MAX - span_c));
      w.rf = coord_t'($urandom_range(0, COORD_MAX - span_r));
      w.cl = w.cf + coord_t'(span_c);
      w.rl = w.rf + coord_t'(span_r);
      if (pick < 70) begin
        w.pc = coord_t'($urandom_range(w.cf, w.cl));
        w.pr = coord_t'($urandom_range(w.rf, w.rl));
      end
    end else begin
      w.cf = coord_t'($urandom);
      w.rf = coord_t'($urandom);
      w.cl = coord_t'($urandom);
      w.rl = coord_t'($urandom);
    end
    return w;
  endfunction

  // present one word at the falling edge, hold it until taken
  task automatic drive_word(input fill_word_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_bus.valid             = 1'b1;
    in_bus.col_first         = w.cf;
    in_bus.row_first         = w.rf;
    in_bus.col_last          = w.cl;
    in_bus.row_last          = w.rl;
    in_bus.gray_top_left     = w.gtl;
    in_bus.gray_top_right    = w.gtr;
    in_bus.gray_bottom_left  = w.gbl;
    in_bus.gray_bottom_right = w.gbr;
    in_bus.pixel_col         = w.pc;
    in_bus.pixel_row         = w.pr;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
  endtask

  // result side back pressure in random bursts
  initial begin
    out_bus.ready = 1'b0;
    stall_left    = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready = 1'b0;
        stall_left--;
      end else begin
        out_bus.ready = 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n                    = 1'b0;
    idle_on                  = 1'b1;
    in_bus.valid             = 1'b0;
    in_bus.col_first         = '0;
    in_bus.row_first         = '0;
    in_bus.col_last          = '0;
    in_bus.row_last          = '0;
    in_bus.gray_top_left     = '0;
    in_bus.gray_top_right    = '0;
    in_bus.gray_bottom_left  = '0;
    in_bus.gray_bottom_right = '0;
    in_bus.pixel_col         = '0;
    in_bus.pixel_row         = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // full-range block: largest sums and the four corners
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 255, 255, 255, 255, COORD_MAX, COORD_MAX));
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 255, 255, 255, 255, 2047, 2048));
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 0, 255, 255, 0, 0, 0));
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 0, 255, 255, 0, COORD_MAX, 0));
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 0, 255, 255, 0, 0, COORD_MAX));
    drive_word(mk_word(0, 0, COORD_MAX, COORD_MAX, 17, 200, 90, 255, 1000, 3000));
    // single point
    drive_word(mk_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 173, 0, 0, 0,
                       COORD_MAX, COORD_MAX));
    drive_word(mk_word(0, 0, 0, 0, 0, 255, 255, 255, 0, 0));
    // single column and single row ignore the off-diagonal corners
    drive_word(mk_word(100, 0, 100, COORD_MAX, 10, 255, 0, 250, 100, 1234));
    drive_word(mk_word(100, 0, 100, COORD_MAX, 10, 255, 0, 250, 100, COORD_MAX));
    drive_word(mk_word(0, COORD_MAX, COORD_MAX, COORD_MAX, 250, 0, 255, 3,
                       COORD_MAX - 1, COORD_MAX));
    drive_word(mk_word(0, COORD_MAX, COORD_MAX, COORD_MAX, 250, 0, 255, 3, 0, COORD_MAX));
    // unordered corners
    drive_word(mk_word(COORD_MAX, 0, 0, COORD_MAX, 1, 2, 3, 4, 2000, 2000));
    drive_word(mk_word(0, COORD_MAX, COORD_MAX, 0, 1, 2, 3, 4, 2000, 2000));
    // pixel just outside on each side
    drive_word(mk_word(10, 10, 20, 20, 9, 9, 9, 9, 9, 15));
    drive_word(mk_word(10, 10, 20, 20, 9, 9, 9, 9, 21, 15));
    drive_word(mk_word(10, 10, 20, 20, 9, 9, 9, 9, 15, 9));
    drive_word(mk_word(10, 10, 20, 20, 9, 9, 9, 9, 15, 21));
    // small blocks near the top and near the bottom of the range
    drive_word(mk_word(4000, 4000, 4001, 4001, 0, 255, 0, 255, 4001, 4000));
    drive_word(mk_word(4000, 4000, 4001, 4001, 255, 0, 0, 0, 4000, 4001));
    drive_word(mk_word(5, 7, 12, 30, 0, 0, 0, 0, 8, 20));
    drive_word(mk_word(5, 7, 12, 30, 255, 0, 128, 64, 11, 29));

    // random words, idling switched per stretch, none in the last part
    for (int i = 0; i < 400; i++) begin
      if (i % 50 == 0) idle_on = (i < 300) && ($urandom_range(0, 3) != 0);
      drive_word(rand_word());
    end
    in_bus.valid = 1'b0;

    wait (pending_count == 0);
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/bbf_pkg.sv
hw/rtl/bbf_in_if.sv
hw/rtl/bbf_out_if.sv
hw/rtl/bbf_div.sv
hw/rtl/bilinear_block_fill_pixel_core.sv
hw/rtl/bbf_chk.sv
dv/bbf_pixel_checker.sv
dv/bilinear_block_fill_pixel_core_tb.sv
